// ===== rtl/srs_pkg.sv =====
package srs_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 11;
   localparam int TYPE_W = 2;
   localparam int RSP_W  = 24;

   // index reported for an absent target (-1)
   localparam logic [IDX_W-1:0] IDX_NONE = '1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
   } result_type;

endpackage

// ===== rtl/srs_store.sv =====
module srs_store #(
   parameter int STORE_DEPTH = 1024,
   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [srs_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [srs_pkg::DATA_W-1:0]  rd_data
);
   import srs_pkg::*;

   logic [DATA_W-1:0] mem [STORE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srs_ctrl.sv =====
module srs_ctrl #(
   parameter int STORE_DEPTH = 1024,
   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [srs_pkg::TYPE_W-1:0]  req_code,
   input  logic [srs_pkg::DATA_W-1:0]  req_value,
   output logic                        res_valid,
   input  logic                        res_ready,
   output srs_pkg::result_type         res,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [srs_pkg::DATA_W-1:0]  mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  logic [srs_pkg::DATA_W-1:0]  mem_rd_data
);
   import srs_pkg::*;

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [CW-1:0] FULL = CW'(STORE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LB,
      S_CHK,
      S_UB,
      S_RSP
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     lb_ff, lb_in;
   logic [DATA_W-1:0] target_ff, target_in;
   result_type        res_ff, res_in;

   logic [CW-1:0]     half;
   logic [CW-1:0]     mid;
   logic [CW-1:0]     step_lo;
   logic [CW-1:0]     step_len;
   logic [CW-1:0]     next_mid;
   logic [CW-1:0]     half_count;
   logic              go_right;
   logic [XW-1:0]     lb_x;
   logic [XW-1:0]     last_x;

   // one search step: entry[mid] came back this cycle
   always_comb begin
      half       = len_ff >> 1;
      mid        = lo_ff + half;
      half_count = count_ff >> 1;
      if (state_ff == S_UB) begin
         go_right = $signed(mem_rd_data) <= $signed(target_ff);
      end else begin
         go_right = $signed(mem_rd_data) < $signed(target_ff);
      end
      if (go_right) begin
         step_lo  = mid + CW'(1);
         step_len = len_ff - half - CW'(1);
      end else begin
         step_lo  = lo_ff;
         step_len = half;
      end
      next_mid = step_lo + (step_len >> 1);
      lb_x     = XW'(lb_ff);
      last_x   = XW'(step_lo) - XW'(1);
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      len_in      = len_ff;
      lb_in       = lb_ff;
      target_in   = target_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[AW-1:0];
      mem_wr_data = req_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_code)
                  REQ_APPEND: begin
                     if (count_ff != FULL) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_QUERY: begin
                     target_in = req_value;
                     lo_in     = '0;
                     len_in    = count_ff;
                     if (count_ff == '0) begin
                        res_in   = '{found: 1'b0, first_index: IDX_NONE,
                                     last_index: IDX_NONE};
                        state_in = S_RSP;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = half_count[AW-1:0];
                        state_in    = S_LB;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_LB, S_UB: begin
            lo_in     = step_lo;
            len_in    = step_len;
            mem_rd_en = 1'b1;
            if (step_len == '0) begin
               if (state_ff == S_LB) begin
                  // fetch entry at the lower bound for the hit check
                  lb_in       = step_lo;
                  mem_rd_addr = step_lo[AW-1:0];
                  state_in    = S_CHK;
               end else begin
                  res_in   = '{found: 1'b1, first_index: lb_x[IDX_W-1:0],
                               last_index: last_x[IDX_W-1:0]};
                  state_in = S_RSP;
               end
            end else begin
               mem_rd_addr = next_mid[AW-1:0];
            end
         end

         S_CHK: begin
            if ((lb_ff < count_ff) && (mem_rd_data == target_ff)) begin
               lo_in       = '0;
               len_in      = count_ff;
               mem_rd_en   = 1'b1;
               mem_rd_addr = half_count[AW-1:0];
               state_in    = S_UB;
            end else begin
               res_in   = '{found: 1'b0, first_index: IDX_NONE,
                            last_index: IDX_NONE};
               state_in = S_RSP;
            end
         end

         S_RSP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff     <= lo_in;
      len_ff    <= len_in;
      lb_ff     <= lb_in;
      target_ff <= target_in;
      res_ff    <= res_in;
   end

   // memory is only written from idle, so reads and writes never overlap
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign res_valid = (state_ff == S_RSP);
   assign res       = res_ff;

endmodule

// ===== rtl/sorted_range_search_core.sv =====
// Channel | Dir | Signals                      | Contents
// req     | in  | req_tvalid/tready/tdata/tuser | tdata: value; tuser: req_type
// rsp     | out | rsp_tvalid/tready/tdata       | tdata: found, first/last index
//
// Append and clear items complete in idle, so the block stays ready. A query
// runs a lower-bound search, a hit check and an upper-bound search over the
// held entries; each search step is one read of the single store read port.
// A miss skips the second search. Reset clears the entry count and the
// handshake state; the store is not cleared. A finished result moves into
// the rsp output register; appends and clears are then taken, but the next
// query holds its result in the controller until that register is freed.
module sorted_range_search_core #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [srs_pkg::DATA_W-1:0]   req_tdata,  // [31:0] value
   input  logic [srs_pkg::TYPE_W-1:0]   req_tuser,  // [1:0] req_type
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [srs_pkg::RSP_W-1:0]    rsp_tdata   // [0] found, [11:1] first_index,
                                                    // [22:12] last_index, [23] zero
);
   import srs_pkg::*;

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   logic       res_valid;
   logic       res_ready;
   result_type res;

   // output register parts the controller from the rsp consumer
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   srs_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   srs_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_code    (req_tuser),
      .req_value   (req_tdata),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.last_index, rsp_ff.first_index, rsp_ff.found};

endmodule

// ===== rtl/srs_checker.sv =====
module srs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [srs_pkg::DATA_W-1:0]  req_tdata,
   input logic [srs_pkg::TYPE_W-1:0]  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [srs_pkg::RSP_W-1:0]   rsp_tdata
);
   import srs_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // a miss reports -1 for both indices
   a_miss_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |->
         (rsp_tdata[11:1] == IDX_NONE) && (rsp_tdata[22:12] == IDX_NONE))
      else $error("miss with an index other than -1");

   // a query keeps the block busy in the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_QUERY) |=> !req_tready)
      else $error("new item taken right after a query");

   // no result is offered coming out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind sorted_range_search_core srs_checker u_srs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
